// File: design/sha1_pkg.sv
package sha1_pkg;

  localparam int DIGEST_WORDS = 5;
  localparam int BLOCK_WORDS  = 16;
  localparam int ROUNDS       = 80;
  localparam int PAD_POS      = 56;  // byte position where the length field starts

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  // Control from the sequencer to the schedule window
  typedef struct packed {
    logic       byte_en;   // shift one message byte into the block
    logic [7:0] data_b;
    logic       word_en;   // advance the schedule by one word (one round)
    logic       expand;    // rounds 16..79 use the expanded word
  } sched_ctl_t;

  typedef logic [DIGEST_WORDS-1:0][31:0] hash_vec_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_FOLD  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    PD_MARK = 2'd0,
    PD_ZERO = 2'd1,
    PD_LEN  = 2'd2
  } pad_t;

  function automatic logic [31:0] init_value(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hEFCDAB89;
      3'd2:    v = 32'h98BADCFE;
      3'd3:    v = 32'h10325476;
      default: v = 32'hC3D2E1F0;
    endcase
    return v;
  endfunction

  function automatic hash_vec_t init_vec();
    hash_vec_t v;
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      v[i] = init_value(3'(i));
    end
    return v;
  endfunction

endpackage

// File: design/sha1_hash_engine.sv
// SHA-1 engine, one message word (byte) per input handshake.
// A byte is absorbed in the cycle it is taken; the 64th byte of a block starts the rounds
//   through the shared round unit (S_ROUND, one round per step), then the fold (S_FOLD).
// No new byte is taken while a block is compressed: in_ready is high only in S_IDLE.
// End of message: pad bytes, then each padded block compressed and folded, then 5 digest words.
// Reset (rst_n low, synchronous): idle, empty block, chaining value = SHA-1 IV.
module sha1_hash_engine
  import sha1_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  state_t      state_r, state_nxt;
  pad_t        pad_r, pad_nxt;
  logic [6:0]  rnd_r, rnd_nxt;         // round counter 0..79
  logic [5:0]  cnt_r, cnt_nxt;         // bytes in current block
  logic [63:0] bits_r, bits_nxt;       // message length in bits
  logic [2:0]  len_idx_r, len_idx_nxt; // which length byte goes next
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        fin_r, fin_nxt;         // message closed, padding in progress
  logic        last_r, last_nxt;       // final block under compression
  hash_vec_t   h_r, h_nxt;             // chaining value
  hash_vec_t   v_r, v_nxt;             // working variables a..e
  hash_vec_t   v_rnd;

  sched_ctl_t  ctl;
  logic [31:0] w_cur;
  logic        put;
  logic [7:0]  put_b;
  logic        full;

  sha1_sched u_sched (
    .clk   (clk),
    .ctl_i (ctl),
    .w_o   (w_cur)
  );

  sha1_round u_round (
    .v_i   (v_r),
    .w_i   (w_cur),
    .rnd_i (rnd_r),
    .v_o   (v_rnd)
  );

  // Only the idle state takes message words
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  assign out_data.digest_word = h_r[out_idx_r];
  assign out_data.word_index  = out_idx_r;
  assign out_data.last_word   = (out_idx_r == 3'(DIGEST_WORDS - 1));

  // This byte completes the block
  assign full = (cnt_r == 6'(BLOCK_WORDS * 4 - 1));

  always_comb begin
    state_nxt   = state_r;
    pad_nxt     = pad_r;
    rnd_nxt     = rnd_r;
    cnt_nxt     = cnt_r;
    bits_nxt    = bits_r;
    len_idx_nxt = len_idx_r;
    out_idx_nxt = out_idx_r;
    fin_nxt     = fin_r;
    last_nxt    = last_r;
    h_nxt       = h_r;
    v_nxt       = v_r;
    ctl         = '0;
    put         = 1'b0;
    put_b       = 8'h00;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.byte_present) begin
            put      = 1'b1;
            put_b    = in_data.data_byte;
            bits_nxt = bits_r + 64'd8;
          end
          if (in_data.end_of_message) begin
            fin_nxt = 1'b1;
            pad_nxt = PD_MARK;
          end
          // byte and end together: compress first, padding resumes after the fold
          if (in_data.byte_present && full) begin
            state_nxt = S_ROUND;
          end else if (in_data.end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        put = 1'b1;
        unique case (pad_r)
          PD_MARK: begin
            put_b   = PAD_MARK_BYTE;
            pad_nxt = (cnt_r + 6'd1 == 6'(PAD_POS)) ? PD_LEN : PD_ZERO;
          end
          PD_ZERO: begin
            put_b = 8'h00;
            if (cnt_r + 6'd1 == 6'(PAD_POS)) begin
              pad_nxt = PD_LEN;
            end
          end
          PD_LEN: begin
            put_b       = bits_r[8 * (7 - len_idx_r) +: 8];
            len_idx_nxt = len_idx_r + 3'd1;
          end
          default: begin
            put_b = 8'h00;
          end
        endcase
        if (full) begin
          state_nxt = S_ROUND;
          last_nxt  = (pad_r == PD_LEN);
        end
      end
      S_ROUND: begin
        ctl.word_en = 1'b1;
        ctl.expand  = (rnd_r >= 7'(BLOCK_WORDS));
        v_nxt       = v_rnd;
        if (rnd_r == 7'(ROUNDS - 1)) begin
          rnd_nxt   = '0;
          state_nxt = S_FOLD;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end
      S_FOLD: begin
        for (int i = 0; i < DIGEST_WORDS; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
        if (last_r) begin
          state_nxt = S_OUT;
        end else if (fin_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (out_idx_r == 3'(DIGEST_WORDS - 1)) begin
            out_idx_nxt = '0;
            h_nxt       = init_vec();
            bits_nxt    = '0;
            fin_nxt     = 1'b0;
            last_nxt    = 1'b0;
            len_idx_nxt = '0;
            state_nxt   = S_IDLE;
          end else begin
            out_idx_nxt = out_idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Common byte placement; a full block loads a..e and starts the rounds
    if (put) begin
      ctl.byte_en = 1'b1;
      ctl.data_b  = put_b;
      cnt_nxt     = cnt_r + 6'd1;
      if (full) begin
        v_nxt   = h_r;
        rnd_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pad_r     <= PD_MARK;
      rnd_r     <= '0;
      cnt_r     <= '0;
      bits_r    <= '0;
      len_idx_r <= '0;
      out_idx_r <= '0;
      fin_r     <= 1'b0;
      last_r    <= 1'b0;
      h_r       <= init_vec();
    end else begin
      state_r   <= state_nxt;
      pad_r     <= pad_nxt;
      rnd_r     <= rnd_nxt;
      cnt_r     <= cnt_nxt;
      bits_r    <= bits_nxt;
      len_idx_r <= len_idx_nxt;
      out_idx_r <= out_idx_nxt;
      fin_r     <= fin_nxt;
      last_r    <= last_nxt;
      h_r       <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  // The final block always ends exactly on a block boundary
  a_out_empty_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (cnt_r == '0))
    else $error("digest out with partial block");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (rnd_r < 7'(ROUNDS)))
    else $error("round counter out of range");

  a_round_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && rnd_r == 7'(ROUNDS - 1)) |=> (state_r == S_FOLD))
    else $error("fold did not follow last round");

  a_out_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last_word) |=>
      (out_valid && out_idx_r == $past(out_idx_r) + 3'd1))
    else $error("digest word index skipped");

  a_last_pad: assert property (@(posedge clk) disable iff (!rst_n)
    last_r |-> fin_r)
    else $error("final block without closed message");

endmodule

// File: design/sha1_round.sv
// One SHA-1 round: the shared datapath stepped 80 times per block.
module sha1_round
  import sha1_pkg::*;
(
  input  hash_vec_t   v_i,    // a..e at index 0..4
  input  logic [31:0] w_i,
  input  logic [6:0]  rnd_i,
  output hash_vec_t   v_o
);

  logic [31:0] a, b, c, d, e;
  logic [31:0] f, k;

  assign a = v_i[0];
  assign b = v_i[1];
  assign c = v_i[2];
  assign d = v_i[3];
  assign e = v_i[4];

  always_comb begin
    if (rnd_i < 7'd20) begin
      f = (b & c) | (~b & d);
      k = 32'h5A827999;
    end else if (rnd_i < 7'd40) begin
      f = b ^ c ^ d;
      k = 32'h6ED9EBA1;
    end else if (rnd_i < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = 32'h8F1BBCDC;
    end else begin
      f = b ^ c ^ d;
      k = 32'hCA62C1D6;
    end
  end

  assign v_o[0] = {a[26:0], a[31:27]} + f + e + k + w_i;
  assign v_o[1] = a;
  assign v_o[2] = {b[1:0], b[31:2]};
  assign v_o[3] = c;
  assign v_o[4] = d;

endmodule

// File: design/sha1_sched.sv
// 16-word block / message schedule window.
// Bytes shift in at the bottom (big-endian packing); rounds shift by whole words.
module sha1_sched
  import sha1_pkg::*;
(
  input  logic        clk,
  input  sched_ctl_t  ctl_i,
  output logic [31:0] w_o
);

  logic [31:0] w_r [BLOCK_WORDS];
  logic [31:0] x;

  // w_r[0] = W[t-16], w_r[2] = W[t-14], w_r[8] = W[t-8], w_r[13] = W[t-3]
  assign x   = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign w_o = ctl_i.expand ? {x[30:0], x[31]} : w_r[0];

  always_ff @(posedge clk) begin
    if (ctl_i.byte_en) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
      end
      w_r[BLOCK_WORDS-1] <= {w_r[BLOCK_WORDS-1][23:0], ctl_i.data_b};
    end else if (ctl_i.word_en) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[BLOCK_WORDS-1] <= w_o;
    end
  end

endmodule
